// File: hw/rtl/rtc_epoch_to_calendar_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef RTC_EPOCH_TO_CALENDAR_TOP_MACROS_SVH
`define RTC_EPOCH_TO_CALENDAR_TOP_MACROS_SVH

// Sampled on clk, quiet while rst is high.
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Sampled on clk, checked during reset as well.
`define RTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rtccal_pkg.sv
package rtccal_pkg;

  localparam int TICK_SHIFT = 15;

  localparam logic [11:0] FIRST_YEAR     = 12'd1970;
  localparam logic [1:0]  FIRST_YEAR_M4  = 2'd2;
  localparam logic [6:0]  FIRST_YEAR_M100 = 7'd70;
  localparam logic [8:0]  FIRST_YEAR_M400 = 9'd370;

  localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
  localparam logic [31:0] SECS_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_10_DAYS   = 32'd864000;
  localparam logic [31:0] SECS_DAY       = 32'd86400;
  localparam logic [31:0] SECS_10_HOURS  = 32'd36000;
  localparam logic [31:0] SECS_HOUR      = 32'd3600;
  localparam logic [31:0] SECS_10_MINS   = 32'd600;
  localparam logic [31:0] SECS_MIN       = 32'd60;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY10,
    PH_DAY1,
    PH_HOUR10,
    PH_HOUR1,
    PH_MIN10,
    PH_MIN1
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY10,
    ST_DAY1,
    ST_HOUR10,
    ST_HOUR1,
    ST_MIN10,
    ST_MIN1,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic borrow;
    logic not_set;
    logic last_month;
  } dp_status_t;

  // Length of a month in seconds.
  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [4:0] days;
    case (m)
      4'd1:      days = 5'd31;
      MONTH_FEB: days = leap ? 5'd29 : 5'd28;
      4'd3:      days = 5'd31;
      4'd4:      days = 5'd30;
      4'd5:      days = 5'd31;
      4'd6:      days = 5'd30;
      4'd7:      days = 5'd31;
      4'd8:      days = 5'd31;
      4'd9:      days = 5'd30;
      4'd10:     days = 5'd31;
      4'd11:     days = 5'd30;
      default:   days = 5'd31;
    endcase
    return 32'(days * SECS_DAY);
  endfunction

endpackage

// File: hw/rtl/rtccal_dp.sv
module rtccal_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_data,
  input  logic [31:0]            counter_value,
  input  rtccal_pkg::dp_cmd_t    cmd,
  output rtccal_pkg::dp_status_t status,
  output logic                   not_set,
  output logic [11:0]            year,
  output logic [3:0]             month,
  output logic [4:0]             day,
  output logic [4:0]             hour,
  output logic [5:0]             minute,
  output logic [5:0]             second
);

  logic [31:0] offset;
  logic [31:0] secs;
  logic        ns;
  logic [11:0] yr;
  logic [1:0]  yr_m4;
  logic [6:0]  yr_m100;
  logic [8:0]  yr_m400;
  logic [3:0]  mon;
  logic [4:0]  dom;
  logic [4:0]  hr;
  logic [5:0]  mins;

  logic        leap;
  logic [31:0] k;
  logic [32:0] diff;

  assign leap = ((yr_m4 == 2'd0) && (yr_m100 != 7'd0)) || (yr_m400 == 9'd0);

  always_comb begin
    case (cmd.phase)
      rtccal_pkg::PH_YEAR:   k = leap ? rtccal_pkg::SECS_LEAP_YEAR : rtccal_pkg::SECS_YEAR;
      rtccal_pkg::PH_MONTH:  k = rtccal_pkg::month_secs(mon, leap);
      rtccal_pkg::PH_DAY10:  k = rtccal_pkg::SECS_10_DAYS;
      rtccal_pkg::PH_DAY1:   k = rtccal_pkg::SECS_DAY;
      rtccal_pkg::PH_HOUR10: k = rtccal_pkg::SECS_10_HOURS;
      rtccal_pkg::PH_HOUR1:  k = rtccal_pkg::SECS_HOUR;
      rtccal_pkg::PH_MIN10:  k = rtccal_pkg::SECS_10_MINS;
      rtccal_pkg::PH_MIN1:   k = rtccal_pkg::SECS_MIN;
      default:               k = rtccal_pkg::SECS_MIN;
    endcase
  end

  // Top bit set means secs < k.
  assign diff = {1'b0, secs} - {1'b0, k};

  assign status.borrow     = diff[32];
  assign status.not_set    = ns;
  assign status.last_month = (mon == rtccal_pkg::MONTH_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 32'd0;
    end else if (cfg_we) begin
      offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs    <= offset + (counter_value >> rtccal_pkg::TICK_SHIFT);
      ns      <= (offset == 32'd0);
      yr      <= rtccal_pkg::FIRST_YEAR;
      yr_m4   <= rtccal_pkg::FIRST_YEAR_M4;
      yr_m100 <= rtccal_pkg::FIRST_YEAR_M100;
      yr_m400 <= rtccal_pkg::FIRST_YEAR_M400;
      mon     <= rtccal_pkg::MONTH_JAN;
      dom     <= 5'd1;
      hr      <= 5'd0;
      mins    <= 6'd0;
    end else if (cmd.step) begin
      secs <= diff[31:0];
      case (cmd.phase)
        rtccal_pkg::PH_YEAR: begin
          yr      <= yr + 12'd1;
          yr_m4   <= yr_m4 + 2'd1;
          yr_m100 <= (yr_m100 == 7'd99) ? 7'd0 : yr_m100 + 7'd1;
          yr_m400 <= (yr_m400 == 9'd399) ? 9'd0 : yr_m400 + 9'd1;
        end
        rtccal_pkg::PH_MONTH:  mon  <= mon + 4'd1;
        rtccal_pkg::PH_DAY10:  dom  <= dom + 5'd10;
        rtccal_pkg::PH_DAY1:   dom  <= dom + 5'd1;
        rtccal_pkg::PH_HOUR10: hr   <= hr + 5'd10;
        rtccal_pkg::PH_HOUR1:  hr   <= hr + 5'd1;
        rtccal_pkg::PH_MIN10:  mins <= mins + 6'd10;
        rtccal_pkg::PH_MIN1:   mins <= mins + 6'd1;
        default: ;
      endcase
    end
  end

  // Zero the fields when the clock was never set.
  assign not_set = ns;
  assign year    = ns ? 12'd0 : yr;
  assign month   = ns ? 4'd0  : mon;
  assign day     = ns ? 5'd0  : dom;
  assign hour    = ns ? 5'd0  : hr;
  assign minute  = ns ? 6'd0  : mins;
  assign second  = ns ? 6'd0  : secs[5:0];

endmodule

// File: hw/rtl/rtccal_ctrl.sv
module rtccal_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rtccal_pkg::dp_status_t status,
  output rtccal_pkg::dp_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);

  rtccal_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtccal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Each state steps while no borrow (month: < Dec; year: set), then moves on.
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.phase  = rtccal_pkg::PH_YEAR;
    busy       = (state != rtccal_pkg::ST_IDLE);
    done       = 1'b0;
    case (state)
      rtccal_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rtccal_pkg::ST_YEAR;
        end
      end
      rtccal_pkg::ST_YEAR: begin
        cmd.phase = rtccal_pkg::PH_YEAR;
        if (status.not_set) begin
          state_next = rtccal_pkg::ST_DONE;
        end else if (status.borrow) begin
          state_next = rtccal_pkg::ST_MONTH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      rtccal_pkg::ST_MONTH: begin
        cmd.phase = rtccal_pkg::PH_MONTH;
        if (status.borrow || status.last_month) begin
          state_next = rtccal_pkg::ST_DAY10;
        end else begin
          cmd.step = 1'b1;
        end
      end
      rtccal_pkg::ST_DAY10: begin
        cmd.phase = rtccal_pkg::PH_DAY10;
        if (status.borrow) state_next = rtccal_pkg::ST_DAY1;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_DAY1: begin
        cmd.phase = rtccal_pkg::PH_DAY1;
        if (status.borrow) state_next = rtccal_pkg::ST_HOUR10;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_HOUR10: begin
        cmd.phase = rtccal_pkg::PH_HOUR10;
        if (status.borrow) state_next = rtccal_pkg::ST_HOUR1;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_HOUR1: begin
        cmd.phase = rtccal_pkg::PH_HOUR1;
        if (status.borrow) state_next = rtccal_pkg::ST_MIN10;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_MIN10: begin
        cmd.phase = rtccal_pkg::PH_MIN10;
        if (status.borrow) state_next = rtccal_pkg::ST_MIN1;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_MIN1: begin
        cmd.phase = rtccal_pkg::PH_MIN1;
        if (status.borrow) state_next = rtccal_pkg::ST_DONE;
        else cmd.step = 1'b1;
      end
      rtccal_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = rtccal_pkg::ST_IDLE;
      end
      default: begin
        state_next = rtccal_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/rtc_epoch_to_calendar_top.sv
// Channel   Handshake              Payload
// input     start, busy            counter_value
// config    cfg_valid, cfg_ready   cfg_data (epoch offset)
// result    done (strobe)          not_set, year, month, day, hour, minute, second
//
// One beat at a time: busy stays high from the accepting edge through the done strobe.
// Busy spans one subtraction per whole year past 1970, whole month and decimal digit
// step of day, hour and minute (at most 35); if not set, it ends at the year state.
// The year loop through the single 32-bit subtractor takes the most steps.
// Synchronous reset clears the controller and the epoch offset; cfg_ready is always high.
// Results hold from done (a one-cycle strobe) until the next start and cannot be stalled.
module rtc_epoch_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] counter_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        not_set,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  rtccal_pkg::dp_cmd_t    cmd;
  rtccal_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  rtccal_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rtccal_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .counter_value (counter_value),
    .cmd           (cmd),
    .status        (status),
    .not_set       (not_set),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

// File: hw/rtl/rtccal_chk.sv
`include "rtc_epoch_to_calendar_top_macros.svh"

module rtccal_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        not_set,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);

  logic fields_zero;
  logic fields_ok;

  assign fields_zero = (year == 12'd0) && (month == 4'd0) && (day == 5'd0) &&
                       (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0);
  assign fields_ok   = (year >= 12'd1970) && (month >= 4'd1) && (month <= 4'd12) &&
                       (day >= 5'd1) && (hour <= 5'd23) && (minute <= 6'd59) &&
                       (second <= 6'd59);

  `RTC_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "not idle after reset")
  `RTC_ASSERT(a_accept_busy, (start && !busy) |=> busy && !done, "accepted beat did not start")
  `RTC_ASSERT(a_done_single, done |-> busy ##1 !done, "result strobe not a single busy cycle")
  `RTC_ASSERT(a_not_set_zero, (done && not_set) |-> fields_zero, "fields not zero when not set")
  `RTC_ASSERT(a_fields_range, (done && !not_set) |-> fields_ok, "calendar field out of range")

endmodule

bind rtc_epoch_to_calendar_top rtccal_chk u_chk (.*);
